FILE: hdl/ptq_pkg.sv
// ptq_pkg: sizes, entry type, command, result and sequencer codes for the
// priority task queue, plus small width helpers.
// no dependencies; used by priority_task_queue_with_cancel.
`default_nettype none

package ptq_pkg;

	localparam int QUEUE_DEPTH   = 16;
	localparam int PRIORITY_BITS = 8;

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

	typedef struct packed {
		logic [15:0]              handle;
		logic [15:0]              ident;
		logic [PRIORITY_BITS-1:0] prio;
	} entry_t;

	typedef enum logic [2:0] {
		CMD_ADD        = 3'd0,
		CMD_EXTRACT    = 3'd1,
		CMD_CANCEL     = 3'd2,
		CMD_CANCEL_ALL = 3'd3,
		CMD_FINISH     = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		KIND_ACCEPTED    = 3'd0,
		KIND_FULL        = 3'd1,
		KIND_GRANTED     = 3'd2,
		KIND_NONE        = 3'd3,
		KIND_EXIT        = 3'd4,
		KIND_REJECTED    = 3'd5,
		KIND_FINISHED    = 3'd6,
		KIND_CANCEL_DONE = 3'd7
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_GRANT,
		ST_COUNT,
		ST_CUR,
		ST_WALK,
		ST_DONE
	} state_t;

	// input priority byte into the stored priority width
	function automatic logic [PRIORITY_BITS-1:0] to_prio(input logic [7:0] p);
		logic [31:0] t;
		t = 32'(p);
		return t[PRIORITY_BITS-1:0];
	endfunction

	// stored priority back to the output byte
	function automatic logic [7:0] from_prio(input logic [PRIORITY_BITS-1:0] p);
		logic [31:0] t;
		t = 32'(p);
		return t[7:0];
	endfunction

	// pending count plus current slot, masked to the output width
	function automatic logic [4:0] qsize(input logic [CNT_W-1:0] cnt, input logic cur);
		logic [31:0] t;
		t = 32'(cnt) + 32'(cur);
		return t[4:0];
	endfunction

endpackage

`default_nettype wire

FILE: hdl/priority_task_queue_with_cancel.sv
// priority_task_queue_with_cancel: pending-task store with current slot,
// driven by a small sequencer over one store read port and one compare.
// depends on ptq_pkg.
`default_nettype none

// add, finish, zero-identifier cancel and empty extract answer in the cycle after accept
// extract: a scan of the pending entries, a shift of those behind the best, then the grant
// cancel, cancel-all: count pass, current check, notice pass, then the final word
// output stalls can hold any emitted word; the queue handles one command at a time
// s_tready only with the sequencer idle and the output register free or being emptied
// reset clears pending count, current slot and output valid; the store is never cleared
module priority_task_queue_with_cancel (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [39:0] s_tdata,  // task_handle[15:0], task_ident[31:16], task_priority[39:32]
	input  wire  [2:0]  s_tuser,  // cmd[2:0]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [47:0] m_tdata,  // out_handle[15:0], out_ident[31:16], out_priority[39:32],
	                              // queue_size[44:40], zero fill [47:45]
	output logic [2:0]  m_tuser,  // kind[2:0]
	output logic        m_tlast   // last word of this command
);

	localparam int IDX_W = ptq_pkg::IDX_W;
	localparam int CNT_W = ptq_pkg::CNT_W;

	// pending store, kept in arrival order, one read and one write a cycle
	ptq_pkg::entry_t pend_q [ptq_pkg::QUEUE_DEPTH];

	ptq_pkg::state_t state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic             cur_valid_q, cur_valid_d;
	ptq_pkg::entry_t  cur_q, cur_d;

	// sequencer working registers
	logic [CNT_W-1:0] idx_q, idx_d;
	logic [CNT_W-1:0] w_q, w_d;
	logic [CNT_W-1:0] best_idx_q, best_idx_d;
	ptq_pkg::entry_t  best_q, best_d;
	logic [15:0]      ident_q, ident_d;
	logic             all_q, all_d;
	logic [4:0]       size_q, size_d;

	// output register
	logic             out_valid_q;
	ptq_pkg::kind_t   kind_q;
	ptq_pkg::entry_t  oent_q;
	logic [4:0]       osize_q;
	logic             olast_q;

	// result to load this cycle
	logic             emit;
	ptq_pkg::kind_t   e_kind;
	ptq_pkg::entry_t  e_ent;
	logic [4:0]       e_size;
	logic             e_last;

	// store write port
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	ptq_pkg::entry_t  wr_data;

	logic             out_free;
	logic             accept;
	ptq_pkg::entry_t  in_ent;
	ptq_pkg::entry_t  rd_q;
	logic             rd_match;
	logic             idx_lt;
	logic [CNT_W-1:0] idx_m1;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ptq_pkg::ST_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;

	assign in_ent.handle = s_tdata[15:0];
	assign in_ent.ident  = s_tdata[31:16];
	assign in_ent.prio   = ptq_pkg::to_prio(s_tdata[39:32]);

	// rd_q holds the entry at the walk index, read from the store with the next index
	assign rd_match = all_q || (rd_q.ident == ident_q);
	assign idx_lt   = (idx_q < count_q);
	assign idx_m1   = idx_q - ptq_pkg::CNT_ONE;

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		cur_valid_d = cur_valid_q;
		cur_d       = cur_q;
		idx_d       = idx_q;
		w_d         = w_q;
		best_idx_d  = best_idx_q;
		best_d      = best_q;
		ident_d     = ident_q;
		all_d       = all_q;
		size_d      = size_q;
		emit        = 1'b0;
		e_kind      = ptq_pkg::KIND_ACCEPTED;
		e_ent       = '0;
		e_size      = size_q;
		e_last      = 1'b1;
		wr_en       = 1'b0;
		wr_addr     = count_q[IDX_W-1:0];
		wr_data     = in_ent;

		case (state_q)
			ptq_pkg::ST_IDLE: begin
				if (accept) begin
					case (ptq_pkg::cmd_t'(s_tuser))
						ptq_pkg::CMD_ADD: begin
							emit = 1'b1;
							if (count_q < ptq_pkg::DEPTH_C) begin
								wr_en   = 1'b1;
								count_d = count_q + ptq_pkg::CNT_ONE;
								e_kind  = ptq_pkg::KIND_ACCEPTED;
								e_size  = ptq_pkg::qsize(count_q + ptq_pkg::CNT_ONE,
									cur_valid_q);
							end else begin
								e_kind = ptq_pkg::KIND_FULL;
								e_size = ptq_pkg::qsize(count_q, cur_valid_q);
							end
						end
						ptq_pkg::CMD_EXTRACT: begin
							if (count_q == '0) begin
								cur_valid_d = 1'b0;
								cur_d       = '0;
								emit        = 1'b1;
								e_kind      = ptq_pkg::KIND_NONE;
								e_size      = 5'd0;
							end else begin
								idx_d   = '0;
								state_d = ptq_pkg::ST_SCAN;
							end
						end
						ptq_pkg::CMD_CANCEL, ptq_pkg::CMD_CANCEL_ALL: begin
							if ((ptq_pkg::cmd_t'(s_tuser) == ptq_pkg::CMD_CANCEL) &&
								(in_ent.ident == 16'd0)) begin
								emit   = 1'b1;
								e_kind = ptq_pkg::KIND_REJECTED;
								e_size = ptq_pkg::qsize(count_q, cur_valid_q);
							end else begin
								ident_d = in_ent.ident;
								all_d   = (ptq_pkg::cmd_t'(s_tuser) == ptq_pkg::CMD_CANCEL_ALL);
								idx_d   = '0;
								w_d     = '0;
								state_d = ptq_pkg::ST_COUNT;
							end
						end
						ptq_pkg::CMD_FINISH: begin
							cur_valid_d = 1'b0;
							cur_d       = '0;
							emit        = 1'b1;
							e_kind      = ptq_pkg::KIND_FINISHED;
							e_size      = ptq_pkg::qsize(count_q, 1'b0);
						end
						default: begin
						end
					endcase
				end
			end
			ptq_pkg::ST_SCAN: begin
				// first entry of strictly higher priority wins, so ties keep the earliest
				if (idx_lt) begin
					if ((idx_q == '0) || (rd_q.prio > best_q.prio)) begin
						best_d     = rd_q;
						best_idx_d = idx_q;
					end
					idx_d = idx_q + ptq_pkg::CNT_ONE;
				end else begin
					idx_d   = best_idx_q + ptq_pkg::CNT_ONE;
					state_d = ptq_pkg::ST_SHIFT;
				end
			end
			ptq_pkg::ST_SHIFT: begin
				if (idx_lt) begin
					wr_en   = 1'b1;
					wr_addr = idx_m1[IDX_W-1:0];
					wr_data = rd_q;
					idx_d   = idx_q + ptq_pkg::CNT_ONE;
				end else begin
					count_d     = count_q - ptq_pkg::CNT_ONE;
					cur_d       = best_q;
					cur_valid_d = 1'b1;
					state_d     = ptq_pkg::ST_GRANT;
				end
			end
			ptq_pkg::ST_GRANT: begin
				if (out_free) begin
					emit    = 1'b1;
					e_kind  = ptq_pkg::KIND_GRANTED;
					e_ent   = cur_q;
					e_size  = ptq_pkg::qsize(count_q, 1'b1);
					state_d = ptq_pkg::ST_IDLE;
				end
			end
			ptq_pkg::ST_COUNT: begin
				// survivors are counted first so every notice carries the final size
				if (idx_lt) begin
					if (!rd_match) begin
						w_d = w_q + ptq_pkg::CNT_ONE;
					end
					idx_d = idx_q + ptq_pkg::CNT_ONE;
				end else begin
					size_d  = ptq_pkg::qsize(w_q, cur_valid_q);
					idx_d   = '0;
					w_d     = '0;
					state_d = ptq_pkg::ST_CUR;
				end
			end
			ptq_pkg::ST_CUR: begin
				if (cur_valid_q && (all_q || (cur_q.ident == ident_q))) begin
					if (out_free) begin
						emit    = 1'b1;
						e_kind  = ptq_pkg::KIND_EXIT;
						e_ent   = cur_q;
						e_last  = 1'b0;
						state_d = ptq_pkg::ST_WALK;
					end
				end else begin
					state_d = ptq_pkg::ST_WALK;
				end
			end
			ptq_pkg::ST_WALK: begin
				// matches leave with a notice, the rest slide down to the write index
				if (idx_lt) begin
					if (rd_match) begin
						if (out_free) begin
							emit   = 1'b1;
							e_kind = ptq_pkg::KIND_EXIT;
							e_ent  = rd_q;
							e_last = 1'b0;
							idx_d  = idx_q + ptq_pkg::CNT_ONE;
						end
					end else begin
						wr_en   = 1'b1;
						wr_addr = w_q[IDX_W-1:0];
						wr_data = rd_q;
						w_d     = w_q + ptq_pkg::CNT_ONE;
						idx_d   = idx_q + ptq_pkg::CNT_ONE;
					end
				end else begin
					count_d = w_q;
					state_d = ptq_pkg::ST_DONE;
				end
			end
			ptq_pkg::ST_DONE: begin
				if (out_free) begin
					emit    = 1'b1;
					e_kind  = ptq_pkg::KIND_CANCEL_DONE;
					state_d = ptq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ptq_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control state and current slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cur_valid_q <= 1'b0;
			cur_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q     <= count_d;
			cur_valid_q <= cur_valid_d;
			cur_q       <= cur_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// sequencer payload and output word, no reset needed
	always_ff @(posedge clk) begin
		idx_q      <= idx_d;
		w_q        <= w_d;
		best_idx_q <= best_idx_d;
		best_q     <= best_d;
		ident_q    <= ident_d;
		all_q      <= all_d;
		size_q     <= size_d;
		if (emit) begin
			kind_q  <= e_kind;
			oent_q  <= e_ent;
			osize_q <= e_size;
			olast_q <= e_last;
		end
	end

	// store: writes always land below the next read address during a walk
	always_ff @(posedge clk) begin
		if (wr_en) begin
			pend_q[wr_addr] <= wr_data;
		end
		rd_q <= pend_q[idx_d[IDX_W-1:0]];
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, osize_q, ptq_pkg::from_prio(oent_q.prio), oent_q.ident,
		oent_q.handle};
	assign m_tuser  = kind_q;
	assign m_tlast  = olast_q;

	// store never overfills
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ptq_pkg::DEPTH_C)
		else $error("pending count beyond store depth");

	// only exit notices can be non-final words of a command
	a_nonlast_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> (m_tuser == ptq_pkg::KIND_EXIT))
		else $error("non-final word that is not an exit notice");

	// a waiting grant always has its task in the current slot
	a_grant_current: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == ptq_pkg::KIND_GRANTED)) |-> cur_valid_q)
		else $error("grant shown without a current task");

	// compaction write index never overtakes the read index
	a_walk_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ptq_pkg::ST_WALK) |-> (w_q <= idx_q))
		else $error("compaction write index ahead of read index");

endmodule

`default_nettype wire
